/* src/tun_pkg.sv */
`default_nettype none
package tun_pkg;
   localparam int CoordW    = 16;
   localparam int EdgeW     = CoordW + 1;
   localparam int ProdW     = 2 * EdgeW;
   localparam int MagW      = ProdW;
   localparam int HalfW     = MagW / 2;
   localparam int SqW       = 2 * MagW;
   localparam int LenW      = SqW + 2;
   localparam int RootW     = LenW / 2;
   localparam int RemW      = RootW + 3;
   localparam int DivW      = RootW + 1;
   localparam int UnitShift = 14;
   localparam int QuotW     = UnitShift + 1;
   localparam int OutW      = 16;
   localparam int UnitOne   = 1 << UnitShift;
   localparam int Lanes     = 3;
   localparam int LaneLat   = 4;
   localparam int PipeLat   = 1 + LaneLat + 1 + RootW + QuotW + 1;

   typedef struct packed {
      logic            neg;
      logic [MagW-1:0] mag;
   } comp_type;

   typedef comp_type [Lanes-1:0] comp_vec_type;

   typedef struct packed {
      comp_vec_type comp;
      logic         degen;
   } side_type;
endpackage
`default_nettype wire

/* src/tun_cross.sv */
`default_nettype none
module tun_cross
   import tun_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    ce,
   input  wire logic signed [EdgeW-1:0] a,
   input  wire logic signed [EdgeW-1:0] b,
   input  wire logic signed [EdgeW-1:0] c,
   input  wire logic signed [EdgeW-1:0] d,
   output comp_type                     comp,
   output logic [SqW-1:0]               sq
);
   logic signed [ProdW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   comp_type                c1_ff, c1_in, c2_ff, c3_ff;
   logic [MagW-1:0]         hh_ff, hl_ff, ll_ff;
   logic [HalfW-1:0]        hi, lo;
   logic [SqW-1:0]          sq_ff, sq_in;
   logic signed [ProdW:0]   diff;
   logic [ProdW:0]          diff_mag;

   assign pa_in = ProdW'(a * b);
   assign pb_in = ProdW'(c * d);

   always_comb begin
      diff      = $signed({pa_ff[ProdW-1], pa_ff}) - $signed({pb_ff[ProdW-1], pb_ff});
      diff_mag  = diff[ProdW] ? (ProdW+1)'(-diff) : diff;
      c1_in.neg = diff[ProdW];
      c1_in.mag = diff_mag[MagW-1:0];
   end

   assign hi = c1_ff.mag[MagW-1:HalfW];
   assign lo = c1_ff.mag[HalfW-1:0];

   // The square is built from three registered half-width products, which are then summed.
   assign sq_in = {hh_ff, {MagW{1'b0}}} + (SqW'(hl_ff) << (HalfW + 1)) + SqW'(ll_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         c1_ff <= c1_in;
         hh_ff <= hi * hi;
         hl_ff <= hi * lo;
         ll_ff <= lo * lo;
         c2_ff <= c1_ff;
         sq_ff <= sq_in;
         c3_ff <= c2_ff;
      end
   end

   assign comp = c3_ff;
   assign sq   = sq_ff;
endmodule
`default_nettype wire

/* src/tun_sqrt.sv */
`default_nettype none
module tun_sqrt
   import tun_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            ce,
   input  wire logic [LenW-1:0] rad,
   input  wire side_type        side_i,
   output logic [RootW-1:0]     root,
   output side_type             side_o
);
   logic [RemW-1:0]  rem_ff  [RootW];
   logic [RootW-1:0] root_ff [RootW];
   logic [LenW-1:0]  rad_ff  [RootW];
   side_type         side_ff [RootW];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      logic [RemW-1:0]  prev_rem, rem_cur, trial, rem_in;
      logic [RootW-1:0] prev_root, root_in;
      logic [LenW-1:0]  prev_rad;
      side_type         prev_side;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rad  = rad;
         assign prev_side = side_i;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_rad  = rad_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      // One root bit per stage: bring down two radicand bits and try 4*root+1.
      always_comb begin
         rem_cur = {prev_rem[RemW-3:0], prev_rad[LenW-1 -: 2]};
         trial   = RemW'({prev_root, 2'b01});
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = {prev_root[RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_cur;
            root_in = {prev_root[RootW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= prev_rad << 2;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign root   = root_ff[RootW-1];
   assign side_o = side_ff[RootW-1];
endmodule
`default_nettype wire

/* src/tun_div.sv */
`default_nettype none
module tun_div
   import tun_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               ce,
   input  wire logic [RootW-1:0]   len,
   input  wire comp_type           comp,
   output logic signed [OutW-1:0]  norm
);
   logic [DivW-1:0]  r_ff   [QuotW];
   logic [QuotW-1:0] q_ff   [QuotW];
   logic [RootW-1:0] s_ff   [QuotW];
   logic             neg_ff [QuotW];
   logic [QuotW-1:0] mag;

   for (genvar k = 0; k < QuotW; k++) begin : g_stage
      logic [DivW-1:0]  r_cur, r_in;
      logic [QuotW-1:0] prev_q, q_in;
      logic [RootW-1:0] prev_s;
      logic             prev_neg;

      // The magnitude never exceeds the root, so the first step starts from it unshifted.
      if (k == 0) begin : g_first
         assign r_cur    = DivW'(comp.mag);
         assign prev_q   = '0;
         assign prev_s   = len;
         assign prev_neg = comp.neg;
      end else begin : g_next
         assign r_cur    = {r_ff[k-1][DivW-2:0], 1'b0};
         assign prev_q   = q_ff[k-1];
         assign prev_s   = s_ff[k-1];
         assign prev_neg = neg_ff[k-1];
      end

      always_comb begin
         if (r_cur >= DivW'(prev_s)) begin
            r_in = r_cur - DivW'(prev_s);
            q_in = {prev_q[QuotW-2:0], 1'b1};
         end else begin
            r_in = r_cur;
            q_in = {prev_q[QuotW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            r_ff[k]   <= r_in;
            q_ff[k]   <= q_in;
            s_ff[k]   <= prev_s;
            neg_ff[k] <= prev_neg;
         end
      end
   end

   assign mag  = (q_ff[QuotW-1] > QuotW'(UnitOne)) ? QuotW'(UnitOne) : q_ff[QuotW-1];
   assign norm = neg_ff[QuotW-1] ? -$signed(OutW'(mag)) : $signed(OutW'(mag));
endmodule
`default_nettype wire

/* src/triangle_unit_normal.sv */
// Throughput: one triangle per cycle unless stalled; every stage is pipelined,
// the longest parts being the single 35-stage square root and the 15-stage
// divider in each of three lanes.
// The whole pipeline stalls only while the response register holds an untaken beat.
// Reset (synchronous, active high) clears the valid bits; data registers are not reset.
`default_nettype none
module triangle_unit_normal
   import tun_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [9*CoordW-1:0]       req_tdata,  // p1_x, p1_y, p1_z, p2_x, .. p3_z
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [3*OutW-1:0]              rsp_tdata,  // norm_x, norm_y, norm_z
   output logic                           rsp_tuser   // degenerate
);
   logic                    ce;
   logic [PipeLat-1:0]      vld_ff, vld_in;
   logic signed [EdgeW-1:0] u_ff [3];
   logic signed [EdgeW-1:0] v_ff [3];
   logic signed [EdgeW-1:0] p   [9];
   comp_type                comp [Lanes];
   logic [SqW-1:0]          sq   [Lanes];
   logic [LenW-1:0]         len_ff, len_in;
   side_type                side_ff, side_in, side_sq;
   logic [RootW-1:0]        root;
   logic signed [OutW-1:0]  norm [Lanes];
   logic [QuotW-1:0]        degen_ff;
   logic [3*OutW-1:0]       data_ff;
   logic                    user_ff;

   assign ce         = !vld_ff[PipeLat-1] || rsp_tready;
   assign req_tready = ce;
   assign vld_in     = {vld_ff[PipeLat-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar i = 0; i < 9; i++) begin : g_coord
      assign p[i] = $signed({req_tdata[i*CoordW + CoordW-1], req_tdata[i*CoordW +: CoordW]});
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= p[3+i] - p[i];
            v_ff[i] <= p[6+i] - p[i];
         end
      end
   end

   tun_cross u_lane0 (.clock, .ce, .a(u_ff[1]), .b(v_ff[2]), .c(v_ff[1]), .d(u_ff[2]),
                      .comp(comp[0]), .sq(sq[0]));
   tun_cross u_lane1 (.clock, .ce, .a(v_ff[0]), .b(u_ff[2]), .c(u_ff[0]), .d(v_ff[2]),
                      .comp(comp[1]), .sq(sq[1]));
   tun_cross u_lane2 (.clock, .ce, .a(u_ff[0]), .b(v_ff[1]), .c(v_ff[0]), .d(u_ff[1]),
                      .comp(comp[2]), .sq(sq[2]));

   // Merge: squared length from the three lanes, and the zero test on the cross product.
   always_comb begin
      len_in = LenW'(sq[0]) + LenW'(sq[1]) + LenW'(sq[2]);
      for (int i = 0; i < Lanes; i++) begin
         side_in.comp[i] = comp[i];
      end
      side_in.degen = (comp[0].mag == '0) && (comp[1].mag == '0) && (comp[2].mag == '0);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         len_ff  <= len_in;
         side_ff <= side_in;
      end
   end

   tun_sqrt u_sqrt (.clock, .ce, .rad(len_ff), .side_i(side_ff), .root, .side_o(side_sq));

   for (genvar i = 0; i < Lanes; i++) begin : g_div
      tun_div u_div (.clock, .ce, .len(root), .comp(side_sq.comp[i]), .norm(norm[i]));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         degen_ff <= {degen_ff[QuotW-2:0], side_sq.degen};
         if (degen_ff[QuotW-1]) begin
            data_ff <= '0;
         end else begin
            data_ff <= {norm[2], norm[1], norm[0]};
         end
         user_ff <= degen_ff[QuotW-1];
      end
   end

   assign rsp_tvalid = vld_ff[PipeLat-1];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
endmodule
`default_nettype wire
